>>> rtl/dacs_pkg.sv
// Shared types and constants of the Diameter AVP code scanner.
package dacs_pkg;

  localparam int unsigned RegionBytesMaxDefault = 65536;
  localparam int unsigned QueueDepthDefault     = 4;

  localparam logic [23:0] HdrBytes    = 24'd8;
  localparam logic [23:0] VendorBytes = 24'd4;
  localparam logic [2:0]  HdrLastIdx  = 3'd7;
  localparam logic [2:0]  FlagIdx     = 3'd4;

  typedef enum logic [1:0] {
    STATUS_FOUND     = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_INVALID   = 2'd2
  } status_e;

  typedef struct packed {
    status_e     status;
    logic [15:0] avp_offset;
    logic [23:0] avp_bytes;
    logic        vendor_flag;
  } dacs_rec_t;

endpackage

>>> rtl/dacs_front.sv
// Byte scanner: header accumulation, code match, skip count and result records.
module dacs_front import dacs_pkg::*; #(
  parameter int unsigned RegionBytesMax = RegionBytesMaxDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic [31:0] cfg_data_i,
  input  logic        accept_i,
  input  logic [7:0]  data_byte_i,
  input  logic [15:0] region_length_i,
  input  logic        last_byte_i,
  output logic        rec_valid_o,
  output dacs_rec_t   rec_o
);

  localparam int unsigned PosCap   = (RegionBytesMax > 65536) ? 65536 : RegionBytesMax;
  localparam logic [15:0] PosLimit = 16'(PosCap - 1);

  logic [31:0] target_q;
  logic [15:0] pos_q, pos_d;
  logic [2:0]  hidx_q, hidx_d;
  logic [31:0] code_q, code_d;
  logic [7:0]  flag_q, flag_d;
  logic [23:0] len_q, len_d;
  logic [23:0] skip_q, skip_d;
  logic [15:0] hstart_q, hstart_d;
  logic        done_q, done_d;

  logic [15:0] hstart_n;
  logic [23:0] len_n;
  logic [24:0] skip_w;
  logic        bad;

  assign hstart_n = (hidx_q == 3'd0) ? pos_q : hstart_q;
  assign len_n    = {len_q[15:0], data_byte_i};
  assign skip_w   = ({1'b0, len_n} + 25'd3) & ~25'd3;
  assign bad      = (len_n > {8'd0, region_length_i}) || (len_n < HdrBytes);

  always_comb begin
    pos_d       = pos_q;
    hidx_d      = hidx_q;
    code_d      = code_q;
    flag_d      = flag_q;
    len_d       = len_q;
    skip_d      = skip_q;
    hstart_d    = hstart_q;
    done_d      = done_q;
    rec_valid_o = 1'b0;
    rec_o       = '0;
    if (accept_i && !done_q) begin
      if (skip_q != 24'd0) begin
        skip_d = skip_q - 24'd1;
      end else begin
        hstart_d = hstart_n;
        hidx_d   = hidx_q + 3'd1;
        if (hidx_q < FlagIdx) begin
          code_d = {code_q[23:0], data_byte_i};
        end else if (hidx_q == FlagIdx) begin
          flag_d = data_byte_i;
        end else begin
          len_d = len_n;
        end
        if (hidx_q == HdrLastIdx) begin
          rec_o.avp_offset  = hstart_n;
          rec_o.avp_bytes   = len_n;
          rec_o.vendor_flag = flag_q[7];
          if (code_q == target_q) begin
            rec_valid_o  = 1'b1;
            rec_o.status = bad ? STATUS_INVALID : STATUS_FOUND;
          end else if (len_n == 24'd0) begin
            rec_valid_o  = 1'b1;
            rec_o.status = STATUS_INVALID;
          end else if (len_n <= VendorBytes) begin
            // short AVP: next header overlaps the flag and length bytes
            code_d   = {flag_q, len_n};
            flag_d   = '0;
            len_d    = '0;
            hstart_d = hstart_n + 16'd4;
            hidx_d   = FlagIdx;
          end else begin
            skip_d = 24'(skip_w - {1'b0, HdrBytes});
          end
          if (rec_valid_o) begin
            done_d = 1'b1;
          end
        end
      end
      if (!rec_valid_o && last_byte_i) begin
        rec_valid_o  = 1'b1;
        rec_o        = '0;
        rec_o.status = STATUS_NOT_FOUND;
      end
      if (pos_q != PosLimit) begin
        pos_d = pos_q + 16'd1;
      end
    end
    if (accept_i && last_byte_i) begin
      pos_d    = '0;
      hidx_d   = '0;
      code_d   = '0;
      flag_d   = '0;
      len_d    = '0;
      skip_d   = '0;
      hstart_d = '0;
      done_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= '0;
      pos_q    <= '0;
      hidx_q   <= '0;
      code_q   <= '0;
      flag_q   <= '0;
      len_q    <= '0;
      skip_q   <= '0;
      hstart_q <= '0;
      done_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        target_q <= cfg_data_i;
      end
      pos_q    <= pos_d;
      hidx_q   <= hidx_d;
      code_q   <= code_d;
      flag_q   <= flag_d;
      len_q    <= len_d;
      skip_q   <= skip_d;
      hstart_q <= hstart_d;
      done_q   <= done_d;
    end
  end

  a_done_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !rec_valid_o)
    else $error("record emitted after search finished");
  a_match_sets_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rec_valid_o && !last_byte_i) |=> done_q)
    else $error("search not closed after a result");
  a_skip_no_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && !done_q && skip_q != 24'd0) |=> $stable(hidx_q))
    else $error("header index moved during skip");

endmodule

>>> rtl/dacs_queue.sv
// Short result queue between the byte scanner and the result stage.
module dacs_queue import dacs_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      wr_i,
  input  dacs_rec_t wr_data_i,
  input  logic      rd_i,
  output dacs_rec_t rd_data_o,
  output logic      not_empty_o,
  output logic      full_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrMax = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  dacs_rec_t       mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;

  assign rd_data_o   = mem_q[rptr_q];
  assign not_empty_o = cnt_q != '0;
  assign full_o      = cnt_q == CntFull;

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr_i) begin
        wptr_q <= (wptr_q == PtrMax) ? '0 : wptr_q + PtrW'(1);
      end
      if (rd_i) begin
        rptr_q <= (rptr_q == PtrMax) ? '0 : rptr_q + PtrW'(1);
      end
      if (wr_i && !rd_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (rd_i && !wr_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !wr_i)
    else $error("write into full queue");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_i |-> not_empty_o)
    else $error("read from empty queue");

endmodule

>>> rtl/dacs_back.sv
// Result stage: data offset and length, output register.
module dacs_back import dacs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_not_empty_i,
  input  dacs_rec_t   q_data_i,
  output logic        q_rd_o,
  input  logic        pop,
  output logic        empty,
  output logic [1:0]  status_o,
  output logic [15:0] avp_offset_o,
  output logic [23:0] avp_bytes_o,
  output logic [15:0] data_offset_o,
  output logic [23:0] data_length_o,
  output logic        vendor_flag_o
);

  logic        valid_q;
  logic [23:0] head;
  logic [15:0] doff;
  logic [23:0] dlen;
  logic        nf;

  assign head  = q_data_i.vendor_flag ? (HdrBytes + VendorBytes) : HdrBytes;
  assign nf    = q_data_i.status == STATUS_NOT_FOUND;
  assign doff  = nf ? '0 : q_data_i.avp_offset + head[15:0];
  assign dlen  = (nf || q_data_i.avp_bytes < head) ? '0 : q_data_i.avp_bytes - head;
  assign q_rd_o = q_not_empty_i && (!valid_q || pop);
  assign empty = !valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (q_rd_o) begin
      valid_q <= 1'b1;
    end else if (pop) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_rd_o) begin
      status_o      <= q_data_i.status;
      avp_offset_o  <= q_data_i.avp_offset;
      avp_bytes_o   <= q_data_i.avp_bytes;
      data_offset_o <= doff;
      data_length_o <= dlen;
      vendor_flag_o <= q_data_i.vendor_flag;
    end
  end

  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (status_o == STATUS_FOUND || status_o == STATUS_NOT_FOUND ||
                status_o == STATUS_INVALID))
    else $error("bad status on output");
  a_nf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o == STATUS_NOT_FOUND) |-> (data_offset_o == '0 && avp_bytes_o == '0))
    else $error("not-found beat carries nonzero fields");
  a_load_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_rd_o |=> !empty)
    else $error("loaded result not shown");

endmodule

>>> rtl/diameter_avp_code_scanner_core.sv
// Top level of the Diameter AVP code scanner.
// Takes one region byte per cycle while full is low: each byte only updates counters and
// the header accumulator, and a result record is written into a queue of QueueDepth
// entries. full rises only when that queue is full, i.e. when the result reader has
// stalled with QueueDepth + 1 results waiting (QueueDepth in the queue, one in the
// output register). A result goes from the deciding byte into the queue, then into
// the output register that drives the output ports; it waits in the queue while that
// register holds an unpopped result. The target code is written on the cfg channel,
// which is always ready; write it only while no region is in flight.
module diameter_avp_code_scanner_core import dacs_pkg::*; #(
  parameter int unsigned RegionBytesMax = RegionBytesMaxDefault,
  parameter int unsigned QueueDepth     = QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic [15:0] region_length_i,
  input  logic        last_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  status_o,
  output logic [15:0] avp_offset_o,
  output logic [23:0] avp_bytes_o,
  output logic [15:0] data_offset_o,
  output logic [23:0] data_length_o,
  output logic        vendor_flag_o
);

  logic      accept;
  logic      rec_valid;
  dacs_rec_t rec;
  logic      q_rd;
  logic      q_not_empty;
  dacs_rec_t q_data;

  assign cfg_ready_o = 1'b1;
  assign accept      = push && !full;

  dacs_front #(
    .RegionBytesMax(RegionBytesMax)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_data_i     (cfg_data_i),
    .accept_i       (accept),
    .data_byte_i    (data_byte_i),
    .region_length_i(region_length_i),
    .last_byte_i    (last_byte_i),
    .rec_valid_o    (rec_valid),
    .rec_o          (rec)
  );

  dacs_queue #(
    .Depth(QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_i       (rec_valid),
    .wr_data_i  (rec),
    .rd_i       (q_rd),
    .rd_data_o  (q_data),
    .not_empty_o(q_not_empty),
    .full_o     (full)
  );

  dacs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_not_empty_i(q_not_empty),
    .q_data_i     (q_data),
    .q_rd_o       (q_rd),
    .pop          (pop),
    .empty        (empty),
    .status_o     (status_o),
    .avp_offset_o (avp_offset_o),
    .avp_bytes_o  (avp_bytes_o),
    .data_offset_o(data_offset_o),
    .data_length_o(data_length_o),
    .vendor_flag_o(vendor_flag_o)
  );

  a_rec_needs_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_valid |-> accept)
    else $error("record without an accepted beat");
  a_pop_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && !q_not_empty) |=> empty)
    else $error("output not cleared after last pop");
  a_full_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !rec_valid)
    else $error("record produced while queue full");

endmodule
